// ===== sv/abkf_pkg.sv =====
`timescale 1ns / 1ps
// abkf_pkg: widths, step program, opcodes and saturation helpers
// for the angle/bias Kalman filter; no dependencies
package abkf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int OPND_W    = DATA_W + 1;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int WIDE_W    = PROD_W;
   localparam int DIV_W     = DATA_W + FRAC_BITS;
   localparam int CNT_W     = $clog2(DIV_W + 1);
   localparam int DT_W      = 17;
   localparam int NOISE_W   = 31;
   localparam int ADDR_W    = 4;
   localparam int STEP_W    = 6;

   localparam logic [DT_W-1:0] RESET_HUNDREDTH =
      DT_W'(((1 << FRAC_BITS) + 50) / 100);
   localparam logic [NOISE_W-1:0] RESET_TENTH =
      NOISE_W'(((1 << FRAC_BITS) + 5) / 10);
   localparam logic [NOISE_W-1:0] RESET_NOISE_HUNDREDTH =
      NOISE_W'(((1 << FRAC_BITS) + 50) / 100);
   localparam logic signed [PROD_W-1:0] ROUND_HALF =
      PROD_W'(64'sd1 <<< (FRAC_BITS - 1));

   // csr register indexes
   localparam logic [1:0] REG_TIME_STEP   = 2'd0;
   localparam logic [1:0] REG_ANGLE_NOISE = 2'd1;
   localparam logic [1:0] REG_BIAS_NOISE  = 2'd2;
   localparam logic [1:0] REG_MEAS_NOISE  = 2'd3;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_END = 3'd4
   } op_type;

   typedef enum logic [4:0] {
      SRC_ANG   = 5'd0,
      SRC_BIAS  = 5'd1,
      SRC_P0    = 5'd2,
      SRC_P1    = 5'd3,
      SRC_P2    = 5'd4,
      SRC_P3    = 5'd5,
      SRC_Y     = 5'd6,
      SRC_S     = 5'd7,
      SRC_K0    = 5'd8,
      SRC_K1    = 5'd9,
      SRC_RATE  = 5'd10,
      SRC_T     = 5'd11,
      SRC_TMP   = 5'd12,
      SRC_ACC   = 5'd13,
      SRC_GYRO  = 5'd14,
      SRC_DT    = 5'd15,
      SRC_QA    = 5'd16,
      SRC_QB    = 5'd17,
      SRC_MEAS  = 5'd18
   } src_type;

   typedef struct packed {
      op_type  op;
      src_type dst;
      src_type src_a;
      src_type src_b;
   } step_ctrl_type;

   function automatic step_ctrl_type mk(op_type op, src_type d, src_type a, src_type b);
      step_ctrl_type c;
      c.op = op;
      c.dst = d;
      c.src_a = a;
      c.src_b = b;
      return c;
   endfunction

   // one filter update as a list of operations on the shared unit and the divider
   function automatic step_ctrl_type step_ctrl(input logic [STEP_W-1:0] step);
      step_ctrl_type c;
      case (step)
         6'd0:  c = mk(OP_SUB, SRC_T,    SRC_GYRO, SRC_BIAS);
         6'd1:  c = mk(OP_MUL, SRC_TMP,  SRC_DT,   SRC_T);
         6'd2:  c = mk(OP_ADD, SRC_ANG,  SRC_ANG,  SRC_TMP);
         6'd3:  c = mk(OP_MUL, SRC_TMP,  SRC_QB,   SRC_DT);
         6'd4:  c = mk(OP_ADD, SRC_BIAS, SRC_BIAS, SRC_TMP);
         6'd5:  c = mk(OP_SUB, SRC_Y,    SRC_ACC,  SRC_ANG);
         6'd6:  c = mk(OP_ADD, SRC_S,    SRC_P0,   SRC_MEAS);
         6'd7:  c = mk(OP_DIV, SRC_K0,   SRC_P0,   SRC_S);
         6'd8:  c = mk(OP_DIV, SRC_K1,   SRC_P2,   SRC_S);
         6'd9:  c = mk(OP_MUL, SRC_TMP,  SRC_K0,   SRC_Y);
         6'd10: c = mk(OP_ADD, SRC_ANG,  SRC_ANG,  SRC_TMP);
         6'd11: c = mk(OP_MUL, SRC_TMP,  SRC_K1,   SRC_Y);
         6'd12: c = mk(OP_ADD, SRC_BIAS, SRC_BIAS, SRC_TMP);
         6'd13: c = mk(OP_MUL, SRC_TMP,  SRC_K0,   SRC_P0);
         6'd14: c = mk(OP_SUB, SRC_P0,   SRC_P0,   SRC_TMP);
         6'd15: c = mk(OP_MUL, SRC_TMP,  SRC_K0,   SRC_P1);
         6'd16: c = mk(OP_SUB, SRC_P1,   SRC_P1,   SRC_TMP);
         6'd17: c = mk(OP_MUL, SRC_TMP,  SRC_K1,   SRC_P0);
         6'd18: c = mk(OP_SUB, SRC_P2,   SRC_P2,   SRC_TMP);
         6'd19: c = mk(OP_MUL, SRC_TMP,  SRC_K1,   SRC_P1);
         6'd20: c = mk(OP_SUB, SRC_P3,   SRC_P3,   SRC_TMP);
         6'd21: c = mk(OP_SUB, SRC_RATE, SRC_GYRO, SRC_BIAS);
         6'd22: c = mk(OP_MUL, SRC_TMP,  SRC_DT,   SRC_RATE);
         6'd23: c = mk(OP_ADD, SRC_ANG,  SRC_ANG,  SRC_TMP);
         6'd24: c = mk(OP_MUL, SRC_T,    SRC_DT,   SRC_P3);
         6'd25: c = mk(OP_SUB, SRC_T,    SRC_T,    SRC_P1);
         6'd26: c = mk(OP_SUB, SRC_T,    SRC_T,    SRC_P2);
         6'd27: c = mk(OP_ADD, SRC_T,    SRC_T,    SRC_QA);
         6'd28: c = mk(OP_MUL, SRC_TMP,  SRC_DT,   SRC_T);
         6'd29: c = mk(OP_ADD, SRC_P0,   SRC_P0,   SRC_TMP);
         6'd30: c = mk(OP_MUL, SRC_TMP,  SRC_DT,   SRC_P3);
         6'd31: c = mk(OP_SUB, SRC_P1,   SRC_P1,   SRC_TMP);
         6'd32: c = mk(OP_SUB, SRC_P2,   SRC_P2,   SRC_TMP);
         6'd33: c = mk(OP_MUL, SRC_TMP,  SRC_QA,   SRC_DT);
         6'd34: c = mk(OP_ADD, SRC_P3,   SRC_P3,   SRC_TMP);
         default: c = mk(OP_END, SRC_TMP, SRC_TMP, SRC_TMP);
      endcase
      return c;
   endfunction

   // clamp a wide signed value to the 32-bit range
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(64'sh7FFF_FFFF);
      lo = -WIDE_W'(64'sh8000_0000);
      if (v > hi) begin
         return DATA_W'(hi);
      end else if (v < lo) begin
         return DATA_W'(lo);
      end
      return v[DATA_W-1:0];
   endfunction

endpackage

// ===== sv/abkf_if.sv =====
`timescale 1ns / 1ps
// abkf_req_if / abkf_rsp_if: valid/ready channels of the filter
// depends on abkf_pkg for the data width
interface abkf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [abkf_pkg::DATA_W-1:0]   accel_angle;
   logic signed [abkf_pkg::DATA_W-1:0]   gyro_rate;
   modport source (output valid, output accel_angle, output gyro_rate, input ready);
   modport sink   (input valid, input accel_angle, input gyro_rate, output ready);
endinterface

interface abkf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [abkf_pkg::DATA_W-1:0]   angle_estimate;
   logic signed [abkf_pkg::DATA_W-1:0]   rate_estimate;
   logic                                 gain_fault;
   modport source (output valid, output angle_estimate, output rate_estimate,
                   output gain_fault, input ready);
   modport sink   (input valid, input angle_estimate, input rate_estimate,
                   input gain_fault, output ready);
endinterface

// ===== sv/abkf_div.sv =====
`timescale 1ns / 1ps
// abkf_div: restoring divider, one quotient bit per cycle, giving
// sat32((num << FRAC_BITS) / den) truncated toward zero; uses abkf_pkg
module abkf_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [abkf_pkg::DATA_W-1:0]  num,
   input  logic [abkf_pkg::NOISE_W-1:0]        den,
   output logic                                done,
   output logic signed [abkf_pkg::DATA_W-1:0]  quo
);
   import abkf_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DATA_W-1:0]      rem_ff, rem_in;
   logic [DIV_W-1:0]       dvd_ff, dvd_in;
   logic [NOISE_W-1:0]     den_ff, den_in;
   logic                   neg_ff, neg_in;
   logic [DATA_W-1:0]      shifted;
   logic [DATA_W:0]        num_mag;
   logic                   fits;
   logic signed [DIV_W:0]  signed_q;

   // one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      num_mag = num[DATA_W-1] ? -{num[DATA_W-1], num} : {1'b0, num};
      shifted = {rem_ff[DATA_W-2:0], dvd_ff[DIV_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = {num_mag[DATA_W-1:0], {FRAC_BITS{1'b0}}};
         den_in  = den;
         neg_in  = num[DATA_W-1];
      end else if (busy_ff) begin
         rem_in = fits ? shifted - {1'b0, den_ff} : shifted;
         dvd_in = {dvd_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // sign and clamp the magnitude quotient
   assign signed_q = neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});
   assign quo  = sat32(WIDE_W'(signed_q));
   assign done = done_ff;

`ifndef NO_ASSERTIONS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without a running division");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff < CNT_W'(DIV_W)) else $error("divider count overrun");
`endif

endmodule

// ===== sv/angle_bias_kalman_filter.sv =====
`timescale 1ns / 1ps
// angle_bias_kalman_filter: two-state angle/gyro-bias Kalman filter on one
// shared add/multiply unit and a bit-serial divider; uses abkf_pkg, abkf_if, abkf_div
//
//   channel   dir  handshake            payload
//   req_bus   in   valid/ready          accel_angle, gyro_rate (Q16.16)
//   rsp_bus   out  valid/ready          angle_estimate, rate_estimate, gain_fault
//   csr_*     in   apb, pready high     time_step, noise registers at 4*i
//
// one sample runs 35 program steps: the two divisions run on the bit-serial
// divider and the other steps on the shared add/multiply unit; a faulted gain
// skips the divisions and writes zero gains instead.
// req_bus.ready is high only while idle; a result waits in the output register
// while rsp_bus.ready is low, and the next sample may be taken meanwhile.
// synchronous reset clears state, covariance and csr registers to defaults.
module angle_bias_kalman_filter (
   input  logic                          clock,
   input  logic                          reset,
   abkf_req_if.sink                      req_bus,
   abkf_rsp_if.source                    rsp_bus,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [abkf_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import abkf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_DIVW = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     phase_ff, phase_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     fault_ff, fault_in;

   logic [DT_W-1:0]    dt_ff;
   logic [NOISE_W-1:0] qa_ff, qb_ff, meas_ff;

   logic signed [DATA_W-1:0] ang_ff, bias_ff, p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [DATA_W-1:0] y_ff, s_ff, k0_ff, k1_ff, rate_ff, t_ff, tmp_ff;
   logic signed [DATA_W-1:0] acc_ff, gyro_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_angle_ff, rsp_rate_ff;
   logic                     rsp_fault_ff;
   logic                     rsp_load;

   step_ctrl_type            ctl;
   logic signed [OPND_W-1:0] opa, opb;
   logic signed [OPND_W:0]   addsub;
   logic signed [DATA_W-1:0] addsub_res, mul_res, wr_data;
   logic signed [PROD_W-1:0] rounded;
   logic                     wr_en;
   logic                     div_start, div_done;
   logic signed [DATA_W-1:0] div_q;
   logic                     csr_write;

   // operand select
   function automatic logic signed [OPND_W-1:0] pick(input src_type s,
      input logic signed [DATA_W-1:0] ang, bias, p0, p1, p2, p3, y, sv, k0, k1,
      input logic signed [DATA_W-1:0] rate, t, tmp, acc, gyro,
      input logic [DT_W-1:0] dt, input logic [NOISE_W-1:0] qa, qb, meas);
      logic signed [OPND_W-1:0] r;
      case (s)
         SRC_ANG:  r = OPND_W'(ang);
         SRC_BIAS: r = OPND_W'(bias);
         SRC_P0:   r = OPND_W'(p0);
         SRC_P1:   r = OPND_W'(p1);
         SRC_P2:   r = OPND_W'(p2);
         SRC_P3:   r = OPND_W'(p3);
         SRC_Y:    r = OPND_W'(y);
         SRC_S:    r = OPND_W'(sv);
         SRC_K0:   r = OPND_W'(k0);
         SRC_K1:   r = OPND_W'(k1);
         SRC_RATE: r = OPND_W'(rate);
         SRC_T:    r = OPND_W'(t);
         SRC_TMP:  r = OPND_W'(tmp);
         SRC_ACC:  r = OPND_W'(acc);
         SRC_GYRO: r = OPND_W'(gyro);
         SRC_DT:   r = $signed({{(OPND_W-DT_W){1'b0}}, dt});
         SRC_QA:   r = $signed({{(OPND_W-NOISE_W){1'b0}}, qa});
         SRC_QB:   r = $signed({{(OPND_W-NOISE_W){1'b0}}, qb});
         SRC_MEAS: r = $signed({{(OPND_W-NOISE_W){1'b0}}, meas});
         default:  r = '0;
      endcase
      return r;
   endfunction

   // shared arithmetic unit
   always_comb begin
      ctl = step_ctrl(step_ff);
      opa = pick(ctl.src_a, ang_ff, bias_ff, p0_ff, p1_ff, p2_ff, p3_ff, y_ff, s_ff,
                 k0_ff, k1_ff, rate_ff, t_ff, tmp_ff, acc_ff, gyro_ff,
                 dt_ff, qa_ff, qb_ff, meas_ff);
      opb = pick(ctl.src_b, ang_ff, bias_ff, p0_ff, p1_ff, p2_ff, p3_ff, y_ff, s_ff,
                 k0_ff, k1_ff, rate_ff, t_ff, tmp_ff, acc_ff, gyro_ff,
                 dt_ff, qa_ff, qb_ff, meas_ff);
      addsub = (ctl.op == OP_SUB) ? (OPND_W+1)'(opa) - (OPND_W+1)'(opb)
                                  : (OPND_W+1)'(opa) + (OPND_W+1)'(opb);
      addsub_res = sat32(WIDE_W'(addsub));
      rounded = (prod_ff + ROUND_HALF) >>> FRAC_BITS;
      mul_res = sat32(WIDE_W'(rounded));
   end

   // step sequencer
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      phase_in  = phase_ff;
      prod_in   = prod_ff;
      fault_in  = fault_ff;
      wr_en     = 1'b0;
      wr_data   = addsub_res;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_RUN;
               step_in  = '0;
               phase_in = 1'b0;
            end
         end
         ST_RUN: begin
            case (ctl.op)
               OP_ADD, OP_SUB: begin
                  wr_en   = 1'b1;
                  step_in = step_ff + 1'b1;
                  if (ctl.dst == SRC_S) begin
                     fault_in = addsub_res[DATA_W-1] || (addsub_res == '0);
                  end
               end
               OP_MUL: begin
                  if (!phase_ff) begin
                     prod_in  = opa * opb;
                     phase_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     wr_data  = mul_res;
                     phase_in = 1'b0;
                     step_in  = step_ff + 1'b1;
                  end
               end
               OP_DIV: begin
                  if (fault_ff) begin
                     wr_en   = 1'b1;
                     wr_data = '0;
                     step_in = step_ff + 1'b1;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIVW;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_DIVW: begin
            if (div_done) begin
               wr_en    = 1'b1;
               wr_data  = div_q;
               step_in  = step_ff + 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_bus.ready);
   end

   abkf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (opa[DATA_W-1:0]),
      .den   (s_ff[NOISE_W-1:0]),
      .done  (div_done),
      .quo   (div_q)
   );

   // control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         phase_ff     <= 1'b0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ang_ff       <= '0;
         bias_ff      <= '0;
         p0_ff        <= '0;
         p1_ff        <= '0;
         p2_ff        <= '0;
         p3_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en && ctl.dst == SRC_ANG)  ang_ff  <= wr_data;
         if (wr_en && ctl.dst == SRC_BIAS) bias_ff <= wr_data;
         if (wr_en && ctl.dst == SRC_P0)   p0_ff   <= wr_data;
         if (wr_en && ctl.dst == SRC_P1)   p1_ff   <= wr_data;
         if (wr_en && ctl.dst == SRC_P2)   p2_ff   <= wr_data;
         if (wr_en && ctl.dst == SRC_P3)   p3_ff   <= wr_data;
      end
   end

   // scratch registers and sample capture
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (wr_en && ctl.dst == SRC_Y)    y_ff    <= wr_data;
      if (wr_en && ctl.dst == SRC_S)    s_ff    <= wr_data;
      if (wr_en && ctl.dst == SRC_K0)   k0_ff   <= wr_data;
      if (wr_en && ctl.dst == SRC_K1)   k1_ff   <= wr_data;
      if (wr_en && ctl.dst == SRC_RATE) rate_ff <= wr_data;
      if (wr_en && ctl.dst == SRC_T)    t_ff    <= wr_data;
      if (wr_en && ctl.dst == SRC_TMP)  tmp_ff  <= wr_data;
      if (req_bus.valid && req_bus.ready) begin
         acc_ff  <= req_bus.accel_angle;
         gyro_ff <= req_bus.gyro_rate;
      end
      if (rsp_load) begin
         rsp_angle_ff <= ang_ff;
         rsp_rate_ff  <= rate_ff;
         rsp_fault_ff <= fault_ff;
      end
   end

   // csr registers
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff   <= RESET_HUNDREDTH;
         qa_ff   <= RESET_TENTH;
         qb_ff   <= RESET_NOISE_HUNDREDTH;
         meas_ff <= RESET_TENTH;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_TIME_STEP:   dt_ff   <= csr_pwdata[DT_W-1:0];
            REG_ANGLE_NOISE: qa_ff   <= csr_pwdata[NOISE_W-1:0];
            REG_BIAS_NOISE:  qb_ff   <= csr_pwdata[NOISE_W-1:0];
            REG_MEAS_NOISE:  meas_ff <= csr_pwdata[NOISE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_TIME_STEP:   csr_prdata = {{(32-DT_W){1'b0}}, dt_ff};
         REG_ANGLE_NOISE: csr_prdata = {{(32-NOISE_W){1'b0}}, qa_ff};
         REG_BIAS_NOISE:  csr_prdata = {{(32-NOISE_W){1'b0}}, qb_ff};
         REG_MEAS_NOISE:  csr_prdata = {{(32-NOISE_W){1'b0}}, meas_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // channel outputs
   assign req_bus.ready          = (state_ff == ST_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.angle_estimate = rsp_angle_ff;
   assign rsp_bus.rate_estimate  = rsp_rate_ff;
   assign rsp_bus.gain_fault     = rsp_fault_ff;

`ifndef NO_ASSERTIONS
   a_start_program: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (state_ff == ST_RUN && step_ff == '0))
      else $error("accepted sample did not start the program");
   a_fault_zero_gain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && fault_ff) |-> (k0_ff == '0 && k1_ff == '0))
      else $error("faulted sample has nonzero gain");
   a_no_div_on_fault: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVW |-> !fault_ff)
      else $error("division started with non-positive innovation");
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("finished result not presented");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for angle_bias_kalman_filter; bit-exact filter
// predictor in a scoreboard class, apb register writes, random flow control
// depends on abkf_pkg, abkf_if and the filter rtl
module tb;
   import abkf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 400;

   typedef struct {
      logic signed [31:0] angle;
      logic signed [31:0] rate;
      logic               fault;
   } estimate_type;

   // bit-exact filter predictor plus queue of expected estimates
   class kalman_scoreboard;
      longint dt, qa, qb, meas;
      longint ang, bias;
      longint p[4];
      estimate_type pending[$];
      int mismatches;
      int checked;

      function void clear_state();
         dt = RESET_HUNDREDTH; qa = RESET_TENTH;
         qb = RESET_NOISE_HUNDREDTH; meas = RESET_TENTH;
         ang = 0; bias = 0;
         foreach (p[i]) p[i] = 0;
      endfunction

      function longint clamp(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // round half up, then saturate
      function longint fx_mul(longint a, longint b);
         longint prod;
         prod = a * b + (64'sd1 <<< (FRAC_BITS - 1));
         return clamp(prod >>> FRAC_BITS);
      endfunction

      function longint fx_div(longint num, longint den);
         if (den <= 0) return 0;
         return clamp((num * (64'sd1 <<< FRAC_BITS)) / den);
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] v);
         case (idx)
            REG_TIME_STEP:   dt = v[DT_W-1:0];
            REG_ANGLE_NOISE: qa = v[NOISE_W-1:0];
            REG_BIAS_NOISE:  qb = v[NOISE_W-1:0];
            REG_MEAS_NOISE:  meas = v[NOISE_W-1:0];
            default: ;
         endcase
      endfunction

      // note an accepted sample and predict its estimate
      function void note_sample(logic signed [31:0] acc_in, logic signed [31:0] gyro_in);
         longint acc, gyro, y, s, k0, k1, rate, t;
         estimate_type e;
         acc = acc_in; gyro = gyro_in;
         ang  = clamp(ang + fx_mul(dt, clamp(gyro - bias)));
         bias = clamp(bias + fx_mul(qb, dt));
         y = clamp(acc - ang);
         s = clamp(p[0] + meas);
         e.fault = (s <= 0);
         k0 = e.fault ? 0 : fx_div(p[0], s);
         k1 = e.fault ? 0 : fx_div(p[2], s);
         ang  = clamp(ang + fx_mul(k0, y));
         bias = clamp(bias + fx_mul(k1, y));
         p[0] = clamp(p[0] - fx_mul(k0, p[0]));
         p[1] = clamp(p[1] - fx_mul(k0, p[1]));
         p[2] = clamp(p[2] - fx_mul(k1, p[0]));
         p[3] = clamp(p[3] - fx_mul(k1, p[1]));
         rate = clamp(gyro - bias);
         ang  = clamp(ang + fx_mul(dt, rate));
         t = fx_mul(dt, p[3]);
         t = clamp(t - p[1]);
         t = clamp(t - p[2]);
         t = clamp(t + qa);
         p[0] = clamp(p[0] + fx_mul(dt, t));
         p[1] = clamp(p[1] - fx_mul(dt, p[3]));
         p[2] = clamp(p[2] - fx_mul(dt, p[3]));
         p[3] = clamp(p[3] + fx_mul(qa, dt));
         e.angle = ang[31:0];
         e.rate  = rate[31:0];
         pending.push_back(e);
      endfunction

      // compare an accepted result with the oldest prediction
      function void check_estimate(logic signed [31:0] a, logic signed [31:0] r, logic f);
         estimate_type e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: angle %0d rate %0d", a, r);
            return;
         end
         e = pending.pop_front();
         if (a !== e.angle || r !== e.rate || f !== e.fault) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: angle %0d/%0d rate %0d/%0d fault %0b/%0b (exp/act)",
                        e.angle, a, e.rate, r, e.fault, f);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   abkf_req_if req_bus();
   abkf_rsp_if rsp_bus();

   angle_bias_kalman_filter dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   kalman_scoreboard sb = new();
   int idle_cycles = 0;
   int stall_mode = 0;
   int faults_seen = 0;
   int sent = 0;

   always #10 clock = ~clock;

   // result side: sample transfers, predict on input transfers, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) sb.note_sample(req_bus.accel_angle, req_bus.gyro_rate);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (rsp_bus.gain_fault) faults_seen++;
            sb.check_estimate(rsp_bus.angle_estimate, rsp_bus.rate_estimate, rsp_bus.gain_fault);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", sb.pending.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // receiver stall pattern: phases of always ready, random, and long stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_bus.ready <= ($urandom_range(0, 19) == 0);
         endcase
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] v);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= ADDR_W'({idx, 2'b00}); csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // one sample transfer; valid stays high when the next follows directly
   task automatic send_sample(logic [31:0] acc, logic [31:0] gyro, bit keep);
      req_bus.valid <= 1'b1;
      req_bus.accel_angle <= acc;
      req_bus.gyro_rate <= gyro;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      sent++;
      if (!keep) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 255) - 128;
         3: return $urandom;
         default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      endcase
   endfunction

   task automatic random_phase(int n);
      int burst;
      int i;
      i = 0;
      while (i < n) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && i < n) begin
            send_sample(rand_field(), rand_field(), burst > 1 && i < n - 1);
            burst--; i++;
         end
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 300)) @(negedge clock);
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.accel_angle = '0;
      req_bus.gyro_rate = '0;
      sb.clear_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes under reset settings
      send_sample(32'h0000_0000, 32'h0000_0000, 0);
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
      send_sample(32'h8000_0000, 32'h8000_0000, 1);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_sample(32'h0001_0000, 32'hFFFF_0000, 0);
      send_sample(32'hFFFF_FFFF, 32'h0000_0001, 0);
      send_sample(32'h5555_5555, 32'hAAAA_AAAA, 0);
      wait_drained();

      // zero time step and zero noise
      csr_write(REG_TIME_STEP, 32'd0);
      csr_write(REG_ANGLE_NOISE, 32'd0);
      csr_write(REG_BIAS_NOISE, 32'd0);
      csr_write(REG_MEAS_NOISE, 32'd0);
      send_sample(32'h0000_4000, 32'h0000_1000, 0);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 0);
      wait_drained();

      // full-scale noise registers and a unit time step drive covariance to saturation and gain faults
      csr_write(REG_TIME_STEP, 32'h0001_0000);
      csr_write(REG_ANGLE_NOISE, 32'hFFFF_FFFF);
      csr_write(REG_BIAS_NOISE, 32'h7FFF_FFFF);
      csr_write(REG_MEAS_NOISE, 32'h7FFF_FFFF);
      for (int k = 0; k < 8; k++) send_sample(rand_field(), rand_field(), k < 7);
      wait_drained();

      // random phases with random register settings, sender fully paused between
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(REG_TIME_STEP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 2000));
         csr_write(REG_ANGLE_NOISE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 70000));
         csr_write(REG_BIAS_NOISE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 7000));
         csr_write(REG_MEAS_NOISE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 70000));
         random_phase(150);
         wait_drained();
      end

      $display("run covered %0d samples, %0d results checked, %0d gain faults",
               sent, sb.checked, faults_seen);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
sv/abkf_pkg.sv
sv/abkf_if.sv
sv/abkf_div.sv
sv/angle_bias_kalman_filter.sv
tb/sv/tb.sv
